// ===== rtl/core/ips_pkg.sv =====
package ips_pkg;

   // request function codes
   localparam logic [1:0] FN_LOAD    = 2'd0;
   localparam logic [1:0] FN_RESTART = 2'd1;
   localparam logic [1:0] FN_STEP    = 2'd2;
   localparam logic [1:0] FN_STEP_IN = 2'd3;

   // response status codes
   localparam logic [2:0] ST_DONE     = 3'd0;
   localparam logic [2:0] ST_OUTPUT   = 3'd1;
   localparam logic [2:0] ST_NEED_IN  = 3'd2;
   localparam logic [2:0] ST_HALTED   = 3'd3;
   localparam logic [2:0] ST_BAD_OP   = 3'd4;
   localparam logic [2:0] ST_BAD_MODE = 3'd5;
   localparam logic [2:0] ST_RANGE    = 3'd6;

   // opcodes
   localparam logic [6:0] OP_ADD  = 7'd1;
   localparam logic [6:0] OP_MUL  = 7'd2;
   localparam logic [6:0] OP_IN   = 7'd3;
   localparam logic [6:0] OP_OUT  = 7'd4;
   localparam logic [6:0] OP_JT   = 7'd5;
   localparam logic [6:0] OP_JF   = 7'd6;
   localparam logic [6:0] OP_LT   = 7'd7;
   localparam logic [6:0] OP_EQ   = 7'd8;
   localparam logic [6:0] OP_ARB  = 7'd9;
   localparam logic [6:0] OP_HALT = 7'd99;

   // operand modes
   localparam logic [3:0] MODE_POS = 4'd0;
   localparam logic [3:0] MODE_IMM = 4'd1;
   localparam logic [3:0] MODE_REL = 4'd2;

   localparam logic [2:0] OPN_BAD = 3'd7;

   typedef struct packed {
      logic [6:0]       opcode;
      logic [2:0][3:0]  modes;
   } dec_type;

   function automatic logic [2:0] op_count(input logic [6:0] op);
      logic [2:0] n;
      case (op)
         OP_ADD, OP_MUL, OP_LT, OP_EQ: n = 3'd3;
         OP_IN, OP_OUT, OP_ARB:        n = 3'd1;
         OP_JT, OP_JF:                 n = 3'd2;
         OP_HALT:                      n = 3'd0;
         default:                      n = OPN_BAD;
      endcase
      return n;
   endfunction

   // one shift-and-add-3 step on the five low decimal digits
   function automatic logic [19:0] dabble(input logic [19:0] bcd, input logic b);
      logic [19:0] t;
      t = bcd;
      for (int k = 0; k < 5; k++) begin
         if (t[4*k +: 4] >= 4'd5) begin
            t[4*k +: 4] = t[4*k +: 4] + 4'd3;
         end
      end
      return {t[18:0], b};
   endfunction

endpackage

// ===== rtl/core/intcode_processor_step.sv =====
// step: fetch, digit decode, operand reads, execute; multiply adds S_MUL0 to S_MUL3;
// load and restart items go straight to the response. one item at a time, next accepted
// the cycle after the response registers; digit decode and the one read port set this.
// reset: synchronous; after it a clearing pass over all MEM_WORDS words zeroes the word memory
// while req_ready stays low; program counter and relative base reset to zero.
module intcode_processor_step import ips_pkg::*; #(
   parameter int MEM_WORDS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [11:0]        req_address,
   input  logic signed [63:0] req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic signed [63:0] rsp_out_value,
   output logic [11:0]        rsp_next_pc
);

   localparam int AW = $clog2(MEM_WORDS);
   localparam int XW = AW + 2;
   localparam logic [63:0]   LIM   = 64'(MEM_WORDS);
   localparam logic [XW-1:0] LIM_X = XW'(MEM_WORDS);
   localparam logic [16:0]   LIM_L = 17'(MEM_WORDS);
   localparam logic [AW-1:0] LAST  = AW'(MEM_WORDS - 1);

   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_FETCH = 5'd2;
   localparam logic [4:0] S_DINIT = 5'd3;
   localparam logic [4:0] S_DEC   = 5'd4;
   localparam logic [4:0] S_OPC   = 5'd5;
   localparam logic [4:0] S_OPND  = 5'd6;
   localparam logic [4:0] S_OPNDW = 5'd7;
   localparam logic [4:0] S_POST  = 5'd8;
   localparam logic [4:0] S_RDA   = 5'd9;
   localparam logic [4:0] S_RDB   = 5'd10;
   localparam logic [4:0] S_EXEC  = 5'd11;
   localparam logic [4:0] S_MUL0  = 5'd12;
   localparam logic [4:0] S_MUL1  = 5'd13;
   localparam logic [4:0] S_MUL2  = 5'd14;
   localparam logic [4:0] S_MUL3  = 5'd15;
   localparam logic [4:0] S_DONE  = 5'd16;

   logic [4:0]    state_ff, state_in;
   logic [AW-1:0] pc_ff, pc_in;
   logic [63:0]   rb_ff, rb_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          have_ff, have_in;
   logic [63:0]   data_ff, data_in;
   logic [1:0]    i_ff, i_in;
   logic [1:0]    n_ff, n_in;
   logic [AW-1:0] ea_ff [3];
   logic [AW-1:0] ea_in [3];
   logic [AW-1:0] wa_ff, wa_in;
   logic [AW-1:0] next_ff, next_in;
   logic [63:0]   a_ff, a_in, b_ff, b_in;
   logic [63:0]   acc_ff, acc_in, prod_ff, prod_in;
   logic [2:0]    status_ff, status_in;
   logic [63:0]   outv_ff, outv_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [63:0]   rsp_value_ff, rsp_value_in;
   logic [AW-1:0] rsp_pc_ff, rsp_pc_in;

   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [63:0]   mem_wdata, mem_rdata;

   logic          dec_start, dec_busy;
   dec_type       dec;
   logic [63:0]   alu_x, alu_y, alu_sum, alu_prod;
   logic [31:0]   mul_x, mul_y;
   logic          alu_lt, alu_eq;

   logic          accept;
   logic [3:0]    mode_cur;
   logic [2:0]    cnt;
   logic [16:0]   pc_wide;

   ips_bcd u_bcd (
      .clock (clock),
      .reset (reset),
      .start (dec_start),
      .word  (mem_rdata),
      .busy  (dec_busy),
      .dec   (dec)
   );

   ips_alu u_alu (
      .add_x (alu_x),
      .add_y (alu_y),
      .mul_x (mul_x),
      .mul_y (mul_y),
      .sum   (alu_sum),
      .prod  (alu_prod),
      .lt    (alu_lt),
      .eq    (alu_eq)
   );

   ips_mem #(.WORDS(MEM_WORDS), .AW(AW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign req_ready = state_ff == S_IDLE;
   assign accept    = req_valid && req_ready;
   assign mode_cur  = dec.modes[i_ff];
   assign cnt       = op_count(dec.opcode);

   always_comb begin
      logic [16:0]   ld_x;
      logic [XW-1:0] wa_x;
      logic [XW-1:0] seq_x;
      logic [63:0]   e;
      logic          jump;
      logic          bad;
      logic [AW-1:0] target;

      ld_x   = 17'(req_address);
      wa_x   = XW'(pc_ff) + XW'(i_ff) + XW'(1);
      seq_x  = XW'(pc_ff) + XW'(n_ff) + XW'(1);
      e      = '0;
      jump   = 1'b0;
      bad    = 1'b0;
      target = '0;

      state_in  = state_ff;
      pc_in     = pc_ff;
      rb_in     = rb_ff;
      clr_in    = clr_ff;
      have_in   = have_ff;
      data_in   = data_ff;
      i_in      = i_ff;
      n_in      = n_ff;
      ea_in     = ea_ff;
      wa_in     = wa_ff;
      next_in   = next_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      status_in = status_ff;
      outv_in   = outv_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_pc_in     = rsp_pc_ff;

      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      mem_raddr = pc_ff;
      dec_start = 1'b0;
      alu_x     = a_ff;
      alu_y     = b_ff;
      mul_x     = a_ff[31:0];
      mul_y     = b_ff[31:0];

      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               have_in   = req_func == FN_STEP_IN;
               data_in   = req_data;
               outv_in   = '0;
               status_in = ST_DONE;
               case (req_func)
                  FN_LOAD: begin
                     if (ld_x < LIM_L) begin
                        mem_we    = 1'b1;
                        mem_waddr = ld_x[AW-1:0];
                        mem_wdata = req_data;
                     end else begin
                        status_in = ST_RANGE;
                     end
                     state_in = S_DONE;
                  end
                  FN_RESTART: begin
                     pc_in    = '0;
                     rb_in    = '0;
                     state_in = S_DONE;
                  end
                  default: state_in = S_FETCH;
               endcase
            end
         end
         S_FETCH: begin
            state_in = S_DINIT;
         end
         S_DINIT: begin
            if (mem_rdata[63]) begin
               status_in = ST_BAD_OP;
               state_in  = S_DONE;
            end else begin
               dec_start = 1'b1;
               i_in      = '0;
               ea_in     = '{default: '0};
               state_in  = S_DEC;
            end
         end
         S_DEC: begin
            if (!dec_busy) begin
               state_in = S_OPC;
            end
         end
         S_OPC: begin
            if (cnt == OPN_BAD) begin
               status_in = ST_BAD_OP;
               state_in  = S_DONE;
            end else begin
               n_in     = cnt[1:0];
               state_in = (cnt == 3'd0) ? S_POST : S_OPND;
            end
         end
         S_OPND: begin
            if (wa_x >= LIM_X) begin
               status_in = ST_RANGE;
               state_in  = S_DONE;
            end else if (mode_cur > MODE_REL) begin
               status_in = ST_BAD_MODE;
               state_in  = S_DONE;
            end else begin
               mem_raddr = wa_x[AW-1:0];
               wa_in     = wa_x[AW-1:0];
               state_in  = S_OPNDW;
            end
         end
         S_OPNDW: begin
            alu_x = rb_ff;
            alu_y = mem_rdata;
            case (mode_cur)
               MODE_POS: e = mem_rdata;
               MODE_IMM: e = 64'(wa_ff);
               default:  e = alu_sum;
            endcase
            if (e >= LIM) begin
               status_in = ST_RANGE;
               state_in  = S_DONE;
            end else begin
               ea_in[i_ff] = e[AW-1:0];
               i_in        = i_ff + 2'd1;
               state_in    = (3'(i_ff) + 3'd1 == 3'(n_ff)) ? S_POST : S_OPND;
            end
         end
         S_POST: begin
            if (dec.opcode == OP_HALT) begin
               status_in = ST_HALTED;
               state_in  = S_DONE;
            end else if (dec.opcode == OP_IN && !have_ff) begin
               status_in = ST_NEED_IN;
               state_in  = S_DONE;
            end else begin
               mem_raddr = ea_ff[0];
               state_in  = S_RDA;
            end
         end
         S_RDA: begin
            a_in      = mem_rdata;
            mem_raddr = ea_ff[1];
            state_in  = S_RDB;
         end
         S_RDB: begin
            b_in     = mem_rdata;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            jump = (dec.opcode == OP_JT && a_ff != '0) ||
                   (dec.opcode == OP_JF && a_ff == '0);
            if (jump) begin
               bad    = b_ff >= LIM;
               target = b_ff[AW-1:0];
            end else begin
               bad    = seq_x >= LIM_X;
               target = seq_x[AW-1:0];
            end
            if (bad) begin
               status_in = ST_RANGE;
               state_in  = S_DONE;
            end else begin
               next_in = target;
               case (dec.opcode)
                  OP_ADD: begin
                     mem_we    = 1'b1;
                     mem_waddr = ea_ff[2];
                     mem_wdata = alu_sum;
                  end
                  OP_IN: begin
                     mem_we    = 1'b1;
                     mem_waddr = ea_ff[0];
                     mem_wdata = data_ff;
                  end
                  OP_OUT: begin
                     outv_in   = a_ff;
                     status_in = ST_OUTPUT;
                  end
                  OP_LT: begin
                     mem_we    = 1'b1;
                     mem_waddr = ea_ff[2];
                     mem_wdata = 64'(alu_lt);
                  end
                  OP_EQ: begin
                     mem_we    = 1'b1;
                     mem_waddr = ea_ff[2];
                     mem_wdata = 64'(alu_eq);
                  end
                  OP_ARB: begin
                     alu_x = rb_ff;
                     alu_y = a_ff;
                     rb_in = alu_sum;
                  end
                  default: ;
               endcase
               if (dec.opcode == OP_MUL) begin
                  state_in = S_MUL0;
               end else begin
                  pc_in    = target;
                  state_in = S_DONE;
               end
            end
         end
         // low 64 bits of the product from three 32x32 partial products
         S_MUL0: begin
            prod_in  = alu_prod;
            state_in = S_MUL1;
         end
         S_MUL1: begin
            acc_in   = prod_ff;
            mul_y    = b_ff[63:32];
            prod_in  = alu_prod;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            alu_x    = acc_ff;
            alu_y    = {prod_ff[31:0], 32'b0};
            acc_in   = alu_sum;
            mul_x    = a_ff[63:32];
            prod_in  = alu_prod;
            state_in = S_MUL3;
         end
         S_MUL3: begin
            alu_x     = acc_ff;
            alu_y     = {prod_ff[31:0], 32'b0};
            mem_we    = 1'b1;
            mem_waddr = ea_ff[2];
            mem_wdata = alu_sum;
            pc_in     = next_ff;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_value_in  = outv_ff;
               rsp_pc_in     = pc_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         rb_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pc_ff        <= pc_in;
         rb_ff        <= rb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      have_ff       <= have_in;
      data_ff       <= data_in;
      i_ff          <= i_in;
      n_ff          <= n_in;
      ea_ff         <= ea_in;
      wa_ff         <= wa_in;
      next_ff       <= next_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      status_ff     <= status_in;
      outv_ff       <= outv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_pc_ff     <= rsp_pc_in;
   end

   assign pc_wide       = 17'(rsp_pc_ff);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_next_pc   = pc_wide[11:0];

   // memory is written only by the clear sweep, a load, or a committing instruction
   a_mem_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_IDLE || state_ff == S_EXEC ||
                  state_ff == S_MUL3))
      else $error("memory write outside a committing state");

   a_out_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OUTPUT) |-> rsp_out_value == '0)
      else $error("nonzero out_value without output status");

   a_opnd_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OPND) |-> (i_ff < n_ff))
      else $error("operand index beyond operand count");

   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside the completion state");

endmodule

// ===== rtl/core/ips_bcd.sv =====
module ips_bcd import ips_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] word,
   output logic        busy,
   output dec_type     dec
);

   logic [63:0] sh_ff, sh_in;
   logic [19:0] bcd_ff, bcd_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [19:0] step;

   // four binary digits per cycle, only the low five decimal digits are kept
   always_comb begin
      step = bcd_ff;
      for (int j = 0; j < 4; j++) begin
         step = dabble(step, sh_ff[63-j]);
      end
   end

   always_comb begin
      sh_in   = sh_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         sh_in   = word;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in  = {sh_ff[59:0], 4'b0};
         bcd_in = step;
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      sh_ff  <= sh_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign busy       = busy_ff;
   assign dec.opcode = 7'(bcd_ff[7:4]) * 7'd10 + 7'(bcd_ff[3:0]);
   assign dec.modes  = bcd_ff[19:8];

endmodule

// ===== rtl/core/ips_alu.sv =====
module ips_alu (
   input  logic [63:0] add_x,
   input  logic [63:0] add_y,
   input  logic [31:0] mul_x,
   input  logic [31:0] mul_y,
   output logic [63:0] sum,
   output logic [63:0] prod,
   output logic        lt,
   output logic        eq
);

   assign sum  = add_x + add_y;
   assign prod = 64'(mul_x) * 64'(mul_y);
   assign lt   = $signed(add_x) < $signed(add_y);
   assign eq   = add_x == add_y;

endmodule

// ===== rtl/core/ips_mem.sv =====
module ips_mem #(
   parameter int WORDS = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [63:0]   wdata,
   input  logic [AW-1:0] raddr,
   output logic [63:0]   rdata
);

   logic [63:0] word_ff [WORDS];
   logic [63:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         word_ff[waddr] <= wdata;
      end
      rdata_ff <= word_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
